>>> sv/wsdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_pkg: shared types and constants of the WebSocket frame deframer
// Parse phases, result kinds, frame header field constants and the opcode
// to kind mapping.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4,
    PH_DROP = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_PING  = 3'd1,
    KIND_PONG  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_ERR   = 3'd4
  } kind_e;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Extended length byte counts, minus one.
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;

  // Only ping, pong and close have kinds of their own; every other opcode,
  // reserved control opcodes included, maps to data.
  function automatic kind_e kind_of(input logic [3:0] op);
    kind_e k;
    case (op)
      OP_PING:  k = KIND_PING;
      OP_PONG:  k = KIND_PONG;
      OP_CLOSE: k = KIND_CLOSE;
      default:  k = KIND_DATA;
    endcase
    return k;
  endfunction

endpackage

>>> sv/websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
// Results: a result enters the output register as the byte that causes it is
// accepted; header bytes cause one only for a zero-length frame or a stray continuation.
// Throughput: one byte per cycle, header or payload, while no unclaimed result stalls the input,
// set by the single parse stage that updates the frame state and the result register together.
// Reset: asynchronous, active low; the parser waits for a first header byte
// with no message in progress and the output register empty.
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top: byte-serial WebSocket frame parser
// Parses frame headers, unmasks payload bytes and tags each one with its
// kind, its message opcode and frame and message end marks.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Byte stream in.
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  // Results out.
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic [2:0] kind_o,
  output logic [3:0] msg_opcode_o,
  output logic       is_text_o,
  output logic       frame_last_o,
  output logic       message_last_o
);

  // Parser state. All of it is updated by one byte per accepted request, so
  // the whole header and payload walk is a single registered pass.
  wsdf_pkg::phase_e         phase_q, phase_d;
  logic [2:0]               ext_q, ext_d;
  logic                     fin_q, fin_d;
  logic [3:0]               op_q, op_d;
  logic                     masked_q, masked_d;
  logic [LENGTH_BITS-1:0]   rem_q, rem_d;
  logic [31:0]              key_q, key_d;
  logic [1:0]               pos_q, pos_d;
  logic                     frag_q, frag_d;
  logic [3:0]               frag_op_q, frag_op_d;

  // Result register.
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               res_byte_q, res_byte_d;
  logic                     res_has_q, res_has_d;
  wsdf_pkg::kind_e          res_kind_q, res_kind_d;
  logic [3:0]               res_op_q, res_op_d;
  logic                     res_flast_q, res_flast_d;
  logic                     res_mlast_q, res_mlast_d;

  logic                     accept;
  logic                     emit;
  logic                     hdr_done;
  logic                     rem_zero;
  logic [6:0]               len7;
  logic [7:0]               key_byte;
  logic [3:0]               eff_op;

  // A new request is refused only while a finished result sits unclaimed.
  // When the result is being taken in the same cycle, the next byte enters.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign len7     = in_byte_i[6:0];
  assign eff_op   = (op_q == wsdf_pkg::OP_CONT) ? frag_op_q : op_q;

  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    ext_d       = ext_q;
    fin_d       = fin_q;
    op_d        = op_q;
    masked_d    = masked_q;
    rem_d       = rem_q;
    key_d       = key_q;
    pos_d       = pos_q;
    frag_d      = frag_q;
    frag_op_d   = frag_op_q;
    hdr_done    = 1'b0;
    rem_zero    = 1'b0;
    emit        = 1'b0;
    res_byte_d  = 8'd0;
    res_has_d   = 1'b0;
    res_kind_d  = wsdf_pkg::KIND_DATA;
    res_op_d    = 4'd0;
    res_flast_d = 1'b0;
    res_mlast_d = 1'b0;

    if (accept) begin
      unique case (phase_q)
        wsdf_pkg::PH_HDR0: begin
          fin_d   = in_byte_i[7];
          op_d    = in_byte_i[3:0];
          phase_d = wsdf_pkg::PH_HDR1;
        end
        wsdf_pkg::PH_HDR1: begin
          masked_d = in_byte_i[7];
          key_d    = 32'd0;
          pos_d    = 2'd0;
          if (len7 == wsdf_pkg::LEN7_EXT16) begin
            rem_d   = '0;
            ext_d   = wsdf_pkg::EXT16_CNT;
            phase_d = wsdf_pkg::PH_EXT;
          end else if (len7 == wsdf_pkg::LEN7_EXT64) begin
            rem_d   = '0;
            ext_d   = wsdf_pkg::EXT64_CNT;
            phase_d = wsdf_pkg::PH_EXT;
          end else begin
            rem_d = LENGTH_BITS'(len7);
            if (in_byte_i[7]) begin
              phase_d = wsdf_pkg::PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        wsdf_pkg::PH_EXT: begin
          // Big-endian length; bits above LENGTH_BITS fall off the top.
          rem_d = {rem_q[LENGTH_BITS-9:0], in_byte_i};
          if (ext_q != 3'd0) begin
            ext_d = ext_q - 3'd1;
          end else if (masked_q) begin
            phase_d = wsdf_pkg::PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end
        wsdf_pkg::PH_MASK: begin
          key_d = {key_q[23:0], in_byte_i};
          pos_d = pos_q + 2'd1;
          if (pos_q == 2'd3) begin
            hdr_done = 1'b1;
          end
        end
        wsdf_pkg::PH_DATA: begin
          // An unmasked frame has an all-zero key, so the XOR passes the byte.
          pos_d       = pos_q + 2'd1;
          rem_d       = rem_q - LENGTH_BITS'(1);
          rem_zero    = (rem_d == '0);
          emit        = 1'b1;
          res_byte_d  = in_byte_i ^ key_byte;
          res_has_d   = 1'b1;
          res_kind_d  = wsdf_pkg::kind_of(op_q);
          res_op_d    = op_q;
          res_flast_d = rem_zero;
          res_mlast_d = rem_zero && fin_q;
          if (rem_zero) begin
            phase_d = wsdf_pkg::PH_HDR0;
          end
        end
        wsdf_pkg::PH_DROP: begin
          rem_d    = rem_q - LENGTH_BITS'(1);
          rem_zero = (rem_d == '0);
          if (rem_zero) begin
            phase_d = wsdf_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_d = wsdf_pkg::PH_HDR0;
        end
      endcase

      // Header complete: resolve the message opcode and fragment tracking.
      if (hdr_done) begin
        rem_zero = (rem_d == '0);
        if (op_q == wsdf_pkg::OP_CONT && !frag_q) begin
          // A continuation with no message in progress is reported once and
          // its payload is swallowed.
          phase_d     = rem_zero ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_DROP;
          emit        = 1'b1;
          res_kind_d  = wsdf_pkg::KIND_ERR;
          res_flast_d = 1'b1;
        end else begin
          op_d = eff_op;
          if (op_q == wsdf_pkg::OP_CONT) begin
            if (fin_q) begin
              frag_d = 1'b0;
            end
          end else if (!op_q[3]) begin
            if (fin_q) begin
              frag_d = 1'b0;
            end else begin
              frag_d    = 1'b1;
              frag_op_d = op_q;
            end
          end
          if (rem_zero) begin
            // Zero-length frame: a marker result stands in for the payload.
            phase_d     = wsdf_pkg::PH_HDR0;
            emit        = 1'b1;
            res_kind_d  = wsdf_pkg::kind_of(eff_op);
            res_op_d    = eff_op;
            res_flast_d = 1'b1;
            res_mlast_d = fin_q;
          end else begin
            phase_d = wsdf_pkg::PH_DATA;
          end
        end
      end
    end

    // The result register loads a new result or drains when taken.
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsdf_pkg::PH_HDR0;
      ext_q       <= 3'd0;
      fin_q       <= 1'b0;
      op_q        <= 4'd0;
      masked_q    <= 1'b0;
      rem_q       <= '0;
      key_q       <= 32'd0;
      pos_q       <= 2'd0;
      frag_q      <= 1'b0;
      frag_op_q   <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      ext_q       <= ext_d;
      fin_q       <= fin_d;
      op_q        <= op_d;
      masked_q    <= masked_d;
      rem_q       <= rem_d;
      key_q       <= key_d;
      pos_q       <= pos_d;
      frag_q      <= frag_d;
      frag_op_q   <= frag_op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload carries no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_byte_q  <= res_byte_d;
      res_has_q   <= res_has_d;
      res_kind_q  <= res_kind_d;
      res_op_q    <= res_op_d;
      res_flast_q <= res_flast_d;
      res_mlast_q <= res_mlast_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = res_byte_q;
  assign has_byte_o     = res_has_q;
  assign kind_o         = res_kind_q;
  assign msg_opcode_o   = res_op_q;
  assign is_text_o      = (res_kind_q != wsdf_pkg::KIND_ERR) && (res_op_q == wsdf_pkg::OP_TEXT);
  assign frame_last_o   = res_flast_q;
  assign message_last_o = res_mlast_q;

  // While payload is streaming or being dropped, at least one byte remains.
  a_data_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsdf_pkg::PH_DATA || phase_q == wsdf_pkg::PH_DROP) |-> (rem_q != '0))
    else $error("payload phase entered with zero remaining length");

  // Every accepted payload byte shows up as a byte-carrying result next cycle.
  a_data_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == wsdf_pkg::PH_DATA) |=> (out_valid_o && has_byte_o))
    else $error("payload byte accepted without a result");

  // An error marker never carries a byte.
  a_err_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_byte_o) |-> (kind_o != wsdf_pkg::KIND_ERR))
    else $error("error result carries a payload byte");

  // Dropped payload produces no results.
  a_drop_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == wsdf_pkg::PH_DROP) |-> !emit)
    else $error("dropped payload byte produced a result");

endmodule
